### rtl/core/ess_pkg.sv
// ---------------------------------------------------------------------------
// ess_pkg
// Shared types and constants for the element sequence search core.
// ---------------------------------------------------------------------------
package ess_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int ELEM_BITS   = 32;
    localparam longint unsigned MAX_HAYSTACK = 65535;

    localparam int CMD_BITS      = 2;
    localparam int IDX_BITS      = 4;
    localparam int IN_ELEM_BITS  = 32;
    localparam int CFG_BITS      = 5;
    localparam int POS_BITS      = 16;
    localparam int LEN_BITS      = $clog2(MAX_PATTERN + 1);
    localparam int COUNT_BITS    = $clog2(MAX_HAYSTACK + 1);

    localparam logic [CFG_BITS-1:0] CFG_LEN_RESET = CFG_BITS'(1);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_HAY    = 2'd1,
        CMD_FINISH = 2'd2
    } cmd_t;

    typedef logic [ELEM_BITS-1:0] elem_t;

    typedef struct packed {
        logic load;
        logic step;
        logic clear;
        logic enable;
    } cell_ctrl_t;

endpackage

### rtl/core/ess_cell.sv
// ---------------------------------------------------------------------------
// ess_cell
// One pattern position: holds its pattern element and its partial-match bit,
// and extends the match handed over by the previous cell.
// ---------------------------------------------------------------------------
module ess_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  ess_pkg::cell_ctrl_t ctrl,
    input  ess_pkg::elem_t      element,
    input  logic                prev_match,
    output logic                match_next,
    output logic                match_out
);
    import ess_pkg::*;

    elem_t pattern_reg;
    logic  match_reg;

    assign match_next = ctrl.enable && prev_match && (pattern_reg == element);
    assign match_out  = match_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            pattern_reg <= element;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (ctrl.clear) begin
            match_reg <= 1'b0;
        end else if (ctrl.step) begin
            match_reg <= match_next;
        end
    end

endmodule

### rtl/core/element_sequence_search_core.sv
// ---------------------------------------------------------------------------
// element_sequence_search_core
// Streaming search for the first occurrence of an element pattern.
//
// Input channel (s_*): one transfer per command. Load writes s_element to
// pattern slot s_pattern_index (slots past the store are dropped). Haystack
// feeds s_element into the cell chain. Finish reports and clears the stream
// state; pattern and length register are kept.
// Result channel (m_*): one transfer per finish: m_found, m_position (first
// start, else haystack length), m_overflow (element counter saturated).
// Throughput: one command per cycle while s_ready is high; every pattern cell
// compares in parallel and the partial-match bits advance one cell per haystack element.
// Result: the output register takes the result at the finish transfer, so it is
// valid in the cycle after it. s_ready is low only while a result waits and m_ready is low.
// cfg_wr_en/cfg_wr_data write the length register cfg_len_reg; write only while idle.
// Reset (aresetn low, synchronous): stream state cleared, length set to 1,
// no result pending; pattern store is undefined until loaded.
// ---------------------------------------------------------------------------
module element_sequence_search_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [ess_pkg::CFG_BITS-1:0] cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ess_pkg::CMD_BITS-1:0] s_cmd,
    input  logic [ess_pkg::IDX_BITS-1:0] s_pattern_index,
    input  logic [ess_pkg::IN_ELEM_BITS-1:0] s_element,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_found,
    output logic [ess_pkg::POS_BITS-1:0] m_position,
    output logic                         m_overflow
);
    import ess_pkg::*;

    logic [CFG_BITS-1:0]   cfg_len_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] start_reg;
    logic                  found_reg;
    logic                  sat_reg;
    logic                  m_valid_reg;
    logic                  m_found_reg;
    logic                  m_overflow_reg;
    logic [POS_BITS-1:0]   m_position_reg;

    logic [LEN_BITS-1:0]   active_len;
    logic                  xfer;
    logic                  do_load;
    logic                  do_hay;
    logic                  do_finish;
    logic                  count_full;
    logic                  step;
    logic                  hit;
    logic [COUNT_BITS-1:0] pos_full;
    elem_t                 elem_in;

    logic [MAX_PATTERN-1:0] match_next;
    logic [MAX_PATTERN-1:0] match_q;
    logic [MAX_PATTERN-1:0] last_sel;
    cell_ctrl_t             ctrl [MAX_PATTERN];

    assign active_len = (int'(cfg_len_reg) > MAX_PATTERN) ? LEN_BITS'(MAX_PATTERN)
                                                          : LEN_BITS'(cfg_len_reg);
    assign s_ready    = !m_valid_reg || m_ready;
    assign xfer       = s_valid && s_ready;
    assign do_load    = xfer && (s_cmd == CMD_LOAD);
    assign do_hay     = xfer && (s_cmd == CMD_HAY);
    assign do_finish  = xfer && (s_cmd == CMD_FINISH);
    assign count_full = (count_reg == COUNT_BITS'(MAX_HAYSTACK));
    assign step       = do_hay && !count_full;
    assign elem_in    = ELEM_BITS'(s_element);

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic prev;
        if (k == 0) begin : g_head
            assign prev = 1'b1;
        end else begin : g_link
            assign prev = match_q[k-1];
        end

        assign ctrl[k].load   = do_load && (32'(s_pattern_index) == k);
        assign ctrl[k].step   = step;
        assign ctrl[k].clear  = do_finish;
        assign ctrl[k].enable = (int'(active_len) > k);
        assign last_sel[k]    = (int'(active_len) == k + 1);

        ess_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl[k]),
            .element    (elem_in),
            .prev_match (prev),
            .match_next (match_next[k]),
            .match_out  (match_q[k])
        );
    end

    assign hit = |(match_next & last_sel);

    always_comb begin
        if (active_len == '0) begin
            pos_full = '0;
        end else if (found_reg) begin
            pos_full = start_reg;
        end else begin
            pos_full = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_len_reg <= CFG_LEN_RESET;
            count_reg   <= '0;
            start_reg   <= '0;
            found_reg   <= 1'b0;
            sat_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_len_reg <= cfg_wr_data;
            end
            if (do_finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (do_finish) begin
                count_reg   <= '0;
                start_reg   <= '0;
                found_reg   <= 1'b0;
                sat_reg     <= 1'b0;
            end else if (do_hay) begin
                if (count_full) begin
                    sat_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + COUNT_BITS'(1);
                    if (!found_reg && hit) begin
                        found_reg <= 1'b1;
                        start_reg <= count_reg - COUNT_BITS'(active_len) + COUNT_BITS'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_finish) begin
            m_found_reg    <= (active_len == '0) || found_reg;
            m_position_reg <= POS_BITS'(pos_full);
            m_overflow_reg <= sat_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_found    = m_found_reg;
    assign m_position = m_position_reg;
    assign m_overflow = m_overflow_reg;

    a_sat_at_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sat_reg |-> count_full)
        else $error("saturation flag set below counter bound");

    a_start_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> (start_reg < count_reg))
        else $error("match start not below element count");

    a_finish_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        do_finish |=> m_valid)
        else $error("finish transfer gave no result");

endmodule

### bench/element_sequence_search_core_test.sv
// ---------------------------------------------------------------------------
// element_sequence_search_core_test
// Self-checking bench for the element sequence search core. A scoreboard
// class mirrors the partial-match chain, element counter and length register
// and queues the report each finish transfer should produce. Stimulus is a
// short directed opening, then random phases of seeded searches, noise and
// pattern reloads under random idling on both channels, including a long
// result hold-off.
// ---------------------------------------------------------------------------
module element_sequence_search_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ess_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 1_200_000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_PHASE   = 3;
    localparam int SETTLE       = 4;

    typedef struct packed {
        logic                found;
        logic [POS_BITS-1:0] position;
        logic                overflow;
    } search_report_t;

    class search_scoreboard;
        elem_t                   pat [MAX_PATTERN];
        logic [MAX_PATTERN-1:0]  chain;
        logic [POS_BITS-1:0]     count;
        logic                    hit;
        logic [POS_BITS-1:0]     first;
        logic                    sat;
        logic [CFG_BITS-1:0]     plen;
        search_report_t          expected_reports[$];
        int                      errors;
        int                      checked;

        function new();
            foreach (pat[i]) pat[i] = '0;
            plen    = CFG_LEN_RESET;
            errors  = 0;
            checked = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            chain = '0;
            count = '0;
            hit   = 1'b0;
            first = '0;
            sat   = 1'b0;
        endfunction

        function int active_len();
            return (plen > MAX_PATTERN) ? MAX_PATTERN : int'(plen);
        endfunction

        function void take_haystack_element(elem_t e);
            int                     len;
            logic [MAX_PATTERN-1:0] nxt;
            logic                   prev;
            len = active_len();
            nxt = '0;
            if (count >= MAX_HAYSTACK) begin
                sat = 1'b1;
                return;
            end
            for (int k = 0; k < len; k++) begin
                if (k == 0) prev = 1'b1;
                else prev = chain[k-1];
                if (prev && pat[k] == e) nxt[k] = 1'b1;
            end
            chain = nxt;
            if (len > 0 && !hit && nxt[len-1]) begin
                hit   = 1'b1;
                first = count - POS_BITS'(len - 1);
            end
            count++;
        endfunction

        function void note_input(logic [CMD_BITS-1:0] cmd, logic [IDX_BITS-1:0] idx,
                                 elem_t e);
            search_report_t r;
            case (cmd)
                CMD_LOAD: begin
                    pat[idx] = e;
                end
                CMD_HAY: begin
                    take_haystack_element(e);
                end
                CMD_FINISH: begin
                    if (active_len() == 0) begin
                        r.found    = 1'b1;
                        r.position = '0;
                    end else if (hit) begin
                        r.found    = 1'b1;
                        r.position = first;
                    end else begin
                        r.found    = 1'b0;
                        r.position = count;
                    end
                    r.overflow = sat;
                    expected_reports.push_back(r);
                    clear_stream();
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic f, logic [POS_BITS-1:0] p, logic o);
            search_report_t r;
            if (expected_reports.size() == 0) begin
                $error("result transfer with no finish outstanding");
                errors++;
                return;
            end
            r = expected_reports.pop_front();
            checked++;
            if (f !== r.found) begin
                $error("found: expected %0d, got %0d", r.found, f);
                errors++;
            end
            if (p !== r.position) begin
                $error("position: expected %0d, got %0d", r.position, p);
                errors++;
            end
            if (o !== r.overflow) begin
                $error("overflow: expected %0d, got %0d", r.overflow, o);
                errors++;
            end
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_BITS-1:0]     cfg_wr_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [CMD_BITS-1:0]     s_cmd = CMD_LOAD;
    logic [IDX_BITS-1:0]     s_pattern_index = '0;
    logic [IN_ELEM_BITS-1:0] s_element = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_found;
    logic [POS_BITS-1:0]     m_position;
    logic                    m_overflow;

    search_scoreboard sb;
    bit no_idle = 1'b0;
    bit holdoff_req = 1'b0;
    bit holdoff_active = 1'b0;
    int items_sent = 0;
    int length_writes = 0;
    int cycle_count = 0;

    element_sequence_search_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_pattern_index (s_pattern_index),
        .s_element       (s_element),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_found         (m_found),
        .m_position      (m_position),
        .m_overflow      (m_overflow)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_found, m_position, m_overflow);
    end

    function automatic int idle_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // result side: random ready bursts and stalls, or a long counted hold-off
    initial begin
        int g;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (holdoff_req) begin
                holdoff_active = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                holdoff_req = 1'b0;
                holdoff_active = 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
                @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
                g = idle_gap();
                if (g > 0) begin
                    m_ready <= 1'b0;
                    repeat (g) @(negedge aclk);
                end
            end
        end
    end

    // entered and left at a falling edge; valid stays up for a back-to-back transfer
    task automatic send_item(logic [CMD_BITS-1:0] cmd, logic [IDX_BITS-1:0] idx,
                             logic [IN_ELEM_BITS-1:0] e);
        int g;
        g = idle_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= cmd;
        s_pattern_index <= idx;
        s_element       <= e;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(cmd, idx, e);
        if (cmd != CMD_UNUSED) items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_hay(elem_t e);
        send_item(CMD_HAY, IDX_BITS'($urandom), e);
    endtask

    task automatic send_finish();
        send_item(CMD_FINISH, IDX_BITS'($urandom), $urandom);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_reports.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_length(logic [CFG_BITS-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.plen = v;
        length_writes++;
    endtask

    function automatic elem_t pick_elem();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return sb.pat[$urandom_range(0, MAX_PATTERN - 1)];
        if (r < 60) return $urandom_range(0, 2);
        return $urandom;
    endfunction

    function automatic logic [CFG_BITS-1:0] choose_length(int phase);
        int r;
        case (phase)
            0: return 5'd16;
            1: return 5'd31;
            2: return 5'd0;
            3: return 5'd17;
            4: return 5'd1;
            default: begin
                r = $urandom_range(0, 99);
                if (r < 12) return 5'd0;
                if (r < 27) return 5'd16;
                if (r < 37) return CFG_BITS'($urandom_range(17, 31));
                return CFG_BITS'($urandom_range(1, 15));
            end
        endcase
    endfunction

    task automatic reload_pattern();
        bit tiny;
        tiny = 1'($urandom_range(0, 1));
        for (int k = 0; k < MAX_PATTERN; k++)
            send_item(CMD_LOAD, IDX_BITS'(k), tiny ? elem_t'($urandom_range(0, 2)) : $urandom);
    endtask

    // mostly a planted, sometimes corrupted, pattern; otherwise noise
    task automatic run_search(bit close);
        int len;
        int bad;
        int r;
        elem_t e;
        len = sb.active_len();
        if ($urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(0, 6)) send_hay(pick_elem());
            bad = ($urandom_range(0, 2) == 0) ? $urandom_range(0, MAX_PATTERN) : -1;
            for (int k = 0; k < len; k++) begin
                e = sb.pat[k];
                if (k == bad) e = e ^ (32'h1 << $urandom_range(0, 31));
                send_hay(e);
            end
            repeat ($urandom_range(0, 5)) send_hay(pick_elem());
        end else begin
            repeat ($urandom_range(0, 12)) begin
                r = $urandom_range(0, 9);
                if (r < 2) send_item(CMD_LOAD, IDX_BITS'($urandom), pick_elem());
                else if (r < 4) send_item(CMD_UNUSED, IDX_BITS'($urandom), $urandom);
                else if (r < 5) send_finish();
                else send_hay(pick_elem());
            end
        end
        if (close) send_finish();
    endtask

    initial begin
        int random_start;
        int phase;
        sb = new();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: load the whole store, then corner cases at reset length, length zero and length three
        for (int k = 0; k < MAX_PATTERN; k++)
            send_item(CMD_LOAD, IDX_BITS'(k), 32'h1111_1111 * k);
        send_finish();
        send_hay(32'h0);
        send_finish();
        drain();
        write_length(5'd0);
        send_hay(32'hFFFF_FFFF);
        send_finish();
        send_finish();
        drain();
        write_length(5'd3);
        send_hay(32'h0);
        send_item(CMD_UNUSED, '1, 32'hFFFF_FFFF);
        send_finish();

        random_start = items_sent;
        phase = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            drain();
            write_length(choose_length(phase));
            no_idle = (phase == HOLD_PHASE) || ($urandom_range(0, 5) == 0);
            if (phase == HOLD_PHASE) begin
                holdoff_req = 1'b1;
                wait (holdoff_active);
            end
            if ($urandom_range(0, 3) == 0) reload_pattern();
            repeat ($urandom_range(3, 8)) run_search(1'b1);
            if ($urandom_range(0, 2) == 0) run_search(1'b0);
            no_idle = 1'b0;
            phase++;
        end
        send_finish();
        drain();
        repeat (10) @(negedge aclk);

        $display("Covered %0d input transfers and %0d checked reports over %0d length writes,",
                 items_sent, sb.checked, length_writes);
        $display("including empty and clamped lengths and a %0d-cycle result hold-off.",
                 HOLD_CYCLES);
        if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### files.f
rtl/core/ess_pkg.sv
rtl/core/ess_cell.sv
rtl/core/element_sequence_search_core.sv
bench/element_sequence_search_core_test.sv
